// File: design/sbc_pkg.sv
// ============================================================================
// sbc_pkg - shared types and constants of the sprite blitter
// Command codes, orientation codes, register indexes and controller structs.
// ============================================================================
`default_nettype none

package sbc_pkg;

    localparam int unsigned COORD_W  = 12;
    localparam int unsigned COLOR_W  = 24;
    localparam int unsigned INDEX_W  = 12;
    localparam int unsigned MODE_W   = 3;
    localparam int unsigned DIR_W    = 2;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 7;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD = 3'd0,
        MODE_FILL = 3'd1,
        MODE_COPY = 3'd2,
        MODE_DRAW = 3'd3,
        MODE_READ = 3'd4
    } t_mode;

    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_UP    = 2'd1;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_W  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_H  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT0_W  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT0_H  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT1_W  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT1_H  = 3'd5;

    // controller -> datapath
    typedef struct packed {
        logic setup;     // latch command, compute bounds
        logic step;      // advance walk counters, issue one access
        logic clr_step;  // advance clearing counter, write zero
        logic rd_issue;  // issue frame read
        logic rd_load;   // capture frame read data into output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic walk_last; // last pixel of the current walk
        logic empty;     // walk covers nothing
        logic clr_last;  // last entry of the clearing pass
    } t_status;

endpackage

`default_nettype wire

// File: design/sbc_stream_if.sv
// ============================================================================
// sbc_stream_if - valid/ready channel
// Carries one payload of parameterised type between a source and a sink.
// ============================================================================
`default_nettype none

interface sbc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/sbc_ram.sv
// ============================================================================
// sbc_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
`default_nettype none

module sbc_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

// File: design/sbc_ctrl.sv
// ============================================================================
// sbc_ctrl - command sequencer
// Clears the background after reset, then runs one command at a time.
// ============================================================================
`default_nettype none

module sbc_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic [sbc_pkg::MODE_W-1:0] i_mode,
    input  wire logic                 i_out_ready,
    input  wire sbc_pkg::t_status     i_status,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    output sbc_pkg::t_cmd             o_cmd
);
    import sbc_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_SETUP, S_WALK, S_DRAIN, S_READ, S_READ_DATA
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;

    // a read needs the output register free so its result has a place to go
    assign o_in_ready  = (r_state == S_IDLE) &&
                         (!r_out_valid || i_out_ready || i_mode != MODE_READ);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.setup = 1'b1;
                    case (i_mode)
                        MODE_LOAD: n_state = S_IDLE;
                        MODE_READ: begin
                            o_cmd.rd_issue = 1'b1;
                            n_state = S_READ;
                        end
                        MODE_FILL, MODE_COPY, MODE_DRAW: n_state = S_SETUP;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_SETUP: begin
                n_state = i_status.empty ? S_IDLE : S_WALK;
            end
            S_WALK: begin
                o_cmd.step = 1'b1;
                if (i_status.walk_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                o_cmd.step = 1'b1;   // last pipelined write lands
                n_state = S_IDLE;
            end
            S_READ: n_state = S_READ_DATA;
            S_READ_DATA: begin
                o_cmd.rd_load = 1'b1;
                n_out_valid   = 1'b1;
                n_state       = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

`default_nettype wire

// File: design/sbc_datapath.sv
// ============================================================================
// sbc_datapath - address generation and stores of the blitter
// Walks fill, copy and draw one pixel a cycle over background, frame and
// sprite memories; read data is registered and returns in the cycle after its address.
// ============================================================================
`default_nettype none

module sbc_datapath #(
    parameter int unsigned MAX_FRAME_WIDTH  = 64,
    parameter int unsigned MAX_FRAME_HEIGHT = 64,
    parameter int unsigned MAX_SPRITE_SIDE  = 16,
    parameter int unsigned SPRITE_SLOTS     = 2
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire sbc_pkg::t_cmd                 i_cmd,
    output sbc_pkg::t_status                   o_status,
    input  wire logic [sbc_pkg::MODE_W-1:0]    i_mode,
    input  wire logic                          i_slot,
    input  wire logic [sbc_pkg::DIR_W-1:0]     i_direction,
    input  wire logic signed [sbc_pkg::COORD_W-1:0] i_ax,
    input  wire logic signed [sbc_pkg::COORD_W-1:0] i_ay,
    input  wire logic signed [sbc_pkg::COORD_W-1:0] i_bx,
    input  wire logic signed [sbc_pkg::COORD_W-1:0] i_by,
    input  wire logic signed [sbc_pkg::COORD_W-1:0] i_cx,
    input  wire logic signed [sbc_pkg::COORD_W-1:0] i_cy,
    input  wire logic [sbc_pkg::COLOR_W-1:0]   i_color,
    input  wire logic [sbc_pkg::INDEX_W-1:0]   i_pixel_index,
    input  wire logic                          i_cfg_we,
    input  wire logic [sbc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [sbc_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output logic [sbc_pkg::COLOR_W-1:0]        o_read_color,
    output logic [sbc_pkg::INDEX_W-1:0]        o_read_index
);
    import sbc_pkg::*;

    localparam int unsigned FDEPTH  = MAX_FRAME_WIDTH * MAX_FRAME_HEIGHT;
    localparam int unsigned FA_W    = $clog2(FDEPTH);
    localparam int unsigned SLOT_D  = MAX_SPRITE_SIDE * MAX_SPRITE_SIDE;
    localparam int unsigned SDEPTH  = SPRITE_SLOTS * SLOT_D;
    localparam int unsigned SA_W    = $clog2(SDEPTH);
    localparam int unsigned SK_W    = $clog2(SLOT_D) + 1;
    // wide signed working width for coordinates
    localparam int unsigned CW      = 16;

    // ---------------- configuration ----------------
    logic [6:0] r_fw, r_fh;
    logic [4:0] r_s0w, r_s0h, r_s1w, r_s1h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= 7'd64; r_fh <= 7'd64;
            r_s0w <= 5'd16; r_s0h <= 5'd16; r_s1w <= 5'd16; r_s1h <= 5'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRAME_W: r_fw  <= i_cfg_data;
                REG_FRAME_H: r_fh  <= i_cfg_data;
                REG_SLOT0_W: r_s0w <= i_cfg_data[4:0];
                REG_SLOT0_H: r_s0h <= i_cfg_data[4:0];
                REG_SLOT1_W: r_s1w <= i_cfg_data[4:0];
                REG_SLOT1_H: r_s1h <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    function automatic logic [CW-1:0] clamp(input logic [6:0] v, input int unsigned hi);
        if (v == 7'd0) return CW'(1);
        if (32'(v) > hi) return CW'(hi);
        return CW'(v);
    endfunction

    logic [CW-1:0] fw_c, fh_c, sw_c, sh_c;
    assign fw_c = clamp(r_fw, MAX_FRAME_WIDTH);
    assign fh_c = clamp(r_fh, MAX_FRAME_HEIGHT);
    assign sw_c = clamp(i_slot ? {2'b0, r_s1w} : {2'b0, r_s0w}, MAX_SPRITE_SIDE);
    assign sh_c = clamp(i_slot ? {2'b0, r_s1h} : {2'b0, r_s0h}, MAX_SPRITE_SIDE);

    // ---------------- command latch and walk bounds ----------------
    logic [MODE_W-1:0]    r_mode;
    logic [COLOR_W-1:0]   r_color;
    logic signed [CW-1:0] r_x0, r_y0;     // origin (fill: clipped start)
    logic [CW-1:0]        r_nx, r_ny;     // extents
    logic                 r_rev, r_trans;
    logic [SA_W-1:0]      r_base;
    logic [CW-1:0]        r_sw;           // sprite row length
    logic [SK_W-1:0]      r_n1;           // n - 1
    logic                 r_empty;
    logic [CW-1:0]        r_lx, r_ly;
    logic [SK_W-1:0]      r_k;            // sprite index of (lx,ly)
    logic [SK_W-1:0]      r_krow;         // index at start of current lx

    logic signed [CW-1:0] ax, ay, bx, by, cx, cy;
    assign ax = CW'(i_ax); assign ay = CW'(i_ay);
    assign bx = CW'(i_bx); assign by = CW'(i_by);
    assign cx = CW'(i_cx); assign cy = CW'(i_cy);

    logic signed [CW-1:0] f_x0, f_x1, f_y0, f_y1, s_fw, s_fh;
    assign s_fw = signed'(fw_c);
    assign s_fh = signed'(fh_c);
    always_comb begin
        f_x0 = ax;
        f_x1 = bx - CW'(1);
        f_y0 = s_fh - by + CW'(1);
        f_y1 = s_fh - ay;
        if (f_x0 < 0) f_x0 = '0;
        if (f_x1 > s_fw - CW'(1)) f_x1 = s_fw - CW'(1);
        if (f_y0 < 0) f_y0 = '0;
        if (f_y1 > s_fh - CW'(1)) f_y1 = s_fh - CW'(1);
    end

    logic [SK_W-1:0] n_prod;
    assign n_prod = SK_W'(sw_c * sh_c);

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_mode  <= i_mode;
            r_color <= i_color;
            r_rev   <= 1'b0;
            r_trans <= 1'b0;
            r_sw    <= sw_c;
            r_n1    <= n_prod - SK_W'(1);
            r_base  <= SA_W'(32'(i_slot) * SLOT_D);
            r_x0    <= '0; r_y0 <= '0;
            r_nx    <= '0; r_ny <= '0;
            r_empty <= 1'b1;
            case (i_mode)
                MODE_FILL: begin
                    r_x0 <= f_x0; r_y0 <= f_y0;
                    r_nx <= f_x1 - f_x0 + CW'(1);
                    r_ny <= f_y1 - f_y0 + CW'(1);
                    r_empty <= (bx <= ax) || (by <= ay) || (f_x1 < f_x0) || (f_y1 < f_y0);
                end
                MODE_COPY: begin
                    r_nx <= fw_c; r_ny <= fh_c;
                    r_empty <= 1'b0;
                end
                MODE_DRAW: begin
                    r_empty <= (32'(i_slot) >= SPRITE_SLOTS);
                    case (i_direction)
                        DIR_DOWN: begin
                            r_x0 <= bx + cx - ax; r_y0 <= by + cy - ay;
                            r_nx <= sw_c; r_ny <= sh_c;
                        end
                        DIR_UP: begin
                            r_x0 <= ax; r_y0 <= ay; r_rev <= 1'b1;
                            r_nx <= sw_c; r_ny <= sh_c;
                        end
                        DIR_LEFT: begin
                            r_x0 <= bx; r_y0 <= by; r_rev <= 1'b1; r_trans <= 1'b1;
                            r_nx <= sh_c; r_ny <= sw_c;
                        end
                        default: begin
                            r_x0 <= cx; r_y0 <= cy; r_trans <= 1'b1;
                            r_nx <= sh_c; r_ny <= sw_c;
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    // ---------------- walk counters: lx outer, ly inner ----------------
    logic ly_last, lx_last;
    assign ly_last = (r_ly == r_ny - CW'(1));
    assign lx_last = (r_lx == r_nx - CW'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_lx <= '0; r_ly <= '0; r_k <= '0; r_krow <= '0;
        end else if (i_cmd.step) begin
            if (ly_last) begin
                r_ly   <= '0;
                r_lx   <= r_lx + CW'(1);
                // next column start: trans -> +w, else +1
                r_krow <= r_krow + (r_trans ? SK_W'(r_sw) : SK_W'(1));
                r_k    <= r_krow + (r_trans ? SK_W'(r_sw) : SK_W'(1));
            end else begin
                r_ly <= r_ly + CW'(1);
                r_k  <= r_k + (r_trans ? SK_W'(1) : SK_W'(r_sw));
            end
        end
    end

    // ---------------- clearing pass ----------------
    logic [FA_W-1:0] r_clr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr <= '0;
        else if (i_cmd.clr_step) r_clr <= r_clr + FA_W'(1);
    end

    // ---------------- address generation (stage 0) ----------------
    logic signed [CW-1:0] px, py;
    logic                 in_frame;
    logic [CW-1:0]        lin;
    logic [SK_W-1:0]      k_eff;

    always_comb begin
        if (r_mode == MODE_FILL) begin
            px = r_x0 + signed'(r_lx);
            py = r_y0 + signed'(r_ly);
        end else if (r_mode == MODE_COPY) begin
            px = signed'(r_lx);
            py = signed'(r_ly);
        end else begin
            px = r_x0 + signed'(r_lx);
            py = s_fh - r_y0 - signed'(r_ly);
        end
        in_frame = (px >= 0) && (py >= 0) && (px < s_fw) && (py < s_fh);
        lin      = CW'(py * s_fw + px);
        k_eff    = r_rev ? (r_n1 - r_k) : r_k;
    end

    assign o_status.walk_last = ly_last && lx_last;
    assign o_status.empty     = r_empty;
    assign o_status.clr_last  = (r_clr == FA_W'(FDEPTH - 1));

    // stage 1: memories return data, then write
    logic             r_p_valid, r_p_in;
    logic [MODE_W-1:0] r_p_mode;
    logic [FA_W-1:0]  r_p_addr;

    // step in WALK issues; step in DRAIN flushes with no new issue
    logic walk_issue;
    logic r_issue_q;
    assign walk_issue = i_cmd.step && !r_issue_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue_q <= 1'b0;
            r_p_valid <= 1'b0;
        end else begin
            r_issue_q <= i_cmd.step && ly_last && lx_last;
            r_p_valid <= walk_issue;
        end
        r_p_in   <= in_frame;
        r_p_mode <= r_mode;
        r_p_addr <= FA_W'(lin);
    end

    // ---------------- memories ----------------
    logic              bg_we, fr_we, sp_we;
    logic [FA_W-1:0]   bg_waddr, bg_raddr, fr_waddr, fr_raddr;
    logic [COLOR_W-1:0] bg_wdata, bg_rdata, fr_wdata, fr_rdata, sp_rdata;
    logic [SA_W-1:0]   sp_waddr, sp_raddr;
    logic              ld_ok;
    logic [INDEX_W-1:0] r_ridx;
    logic               r_rin;

    assign ld_ok = i_cmd.setup && (i_mode == MODE_LOAD) &&
                   (32'(i_slot) < SPRITE_SLOTS) && (32'(i_pixel_index) < SLOT_D);
    assign sp_we    = ld_ok;
    assign sp_waddr = SA_W'(32'(i_slot) * SLOT_D + 32'(i_pixel_index));
    assign sp_raddr = r_base + SA_W'(k_eff);

    assign bg_we    = i_cmd.clr_step ||
                      (walk_issue && r_mode == MODE_FILL && in_frame);
    assign bg_waddr = i_cmd.clr_step ? r_clr : FA_W'(lin);
    assign bg_wdata = i_cmd.clr_step ? '0 : r_color;
    assign bg_raddr = FA_W'(lin);

    assign fr_we    = r_p_valid && r_p_in &&
                      (r_p_mode == MODE_COPY || r_p_mode == MODE_DRAW);
    assign fr_waddr = r_p_addr;
    assign fr_wdata = (r_p_mode == MODE_COPY) ? bg_rdata : sp_rdata;
    // hold the read address once the input has moved on
    assign fr_raddr = i_cmd.rd_issue ? FA_W'(i_pixel_index) : FA_W'(r_ridx);

    sbc_ram #(.WIDTH(COLOR_W), .DEPTH(FDEPTH)) u_bg (
        .i_clk(i_clk), .i_we(bg_we), .i_waddr(bg_waddr), .i_wdata(bg_wdata),
        .i_raddr(bg_raddr), .o_rdata(bg_rdata));
    sbc_ram #(.WIDTH(COLOR_W), .DEPTH(FDEPTH)) u_fr (
        .i_clk(i_clk), .i_we(fr_we), .i_waddr(fr_waddr), .i_wdata(fr_wdata),
        .i_raddr(fr_raddr), .o_rdata(fr_rdata));
    sbc_ram #(.WIDTH(COLOR_W), .DEPTH(SDEPTH)) u_sp (
        .i_clk(i_clk), .i_we(sp_we), .i_waddr(sp_waddr), .i_wdata(i_color),
        .i_raddr(sp_raddr), .o_rdata(sp_rdata));

    // ---------------- read result ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue) begin
            r_ridx <= i_pixel_index;
            r_rin  <= (32'(i_pixel_index) < FDEPTH);
        end
        if (i_cmd.rd_load) begin
            o_read_color <= r_rin ? fr_rdata : '0;
            o_read_index <= r_ridx;
        end
    end
endmodule

`default_nettype wire

// File: design/sprite_blitter_with_clipping.sv
// ============================================================================
// sprite_blitter_with_clipping - 2D blitter with clipping and sprite rotation
// Load, fill, copy, draw and read over background, frame and sprite stores.
// ============================================================================
//  channel | direction | payload
//  in      | sink      | mode slot direction ax ay bx by cx cy color pixel_index
//  out     | source    | read_color read_index
//  cfg     | write     | i_cfg_we i_cfg_index i_cfg_data
//
//  Fill walks its clipped extent and skips the walk when nothing is left after
//  clipping; draw walks its sprite extent, copy frame_width*frame_height, all one
//  pixel per cycle through the memory port.
//  After reset a clearing pass zeroes all MAX_FRAME_WIDTH*MAX_FRAME_HEIGHT
//  background entries; no transaction is taken meanwhile.
//  A read waits while an earlier result is still unclaimed.
// ============================================================================
`default_nettype none

module sprite_blitter_with_clipping #(
    parameter int unsigned MAX_FRAME_WIDTH  = 64,
    parameter int unsigned MAX_FRAME_HEIGHT = 64,
    parameter int unsigned MAX_SPRITE_SIDE  = 16,
    parameter int unsigned SPRITE_SLOTS     = 2
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    sbc_stream_if.sink                         in_if,
    sbc_stream_if.source                       out_if,
    input  wire logic                          i_cfg_we,
    input  wire logic [sbc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [sbc_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import sbc_pkg::*;

    t_cmd    cmd;
    t_status status;

    sbc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_if.valid), .i_mode(in_if.data.mode),
        .i_out_ready(out_if.ready), .i_status(status),
        .o_in_ready(in_if.ready), .o_out_valid(out_if.valid), .o_cmd(cmd));

    sbc_datapath #(
        .MAX_FRAME_WIDTH(MAX_FRAME_WIDTH), .MAX_FRAME_HEIGHT(MAX_FRAME_HEIGHT),
        .MAX_SPRITE_SIDE(MAX_SPRITE_SIDE), .SPRITE_SLOTS(SPRITE_SLOTS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_mode(in_if.data.mode), .i_slot(in_if.data.slot),
        .i_direction(in_if.data.direction),
        .i_ax(in_if.data.ax), .i_ay(in_if.data.ay),
        .i_bx(in_if.data.bx), .i_by(in_if.data.by),
        .i_cx(in_if.data.cx), .i_cy(in_if.data.cy),
        .i_color(in_if.data.color), .i_pixel_index(in_if.data.pixel_index),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_read_color(out_if.data.read_color),
        .o_read_index(out_if.data.read_index));
endmodule

`default_nettype wire

// File: sim/tb.sv
// ============================================================================
// tb - self-checking testbench for sprite_blitter_with_clipping
// Drives load, fill, copy, draw, read and unused-mode transactions with random stalls,
// mirrors the background, frame and sprite stores, checks every read result.
// ============================================================================
`timescale 1ns / 1ps

module tb;
    import sbc_pkg::*;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic                      slot;
        logic [DIR_W-1:0]          direction;
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [COLOR_W-1:0]        color;
        logic [INDEX_W-1:0]        pixel_index;
    } t_cmd_item;

    typedef struct packed {
        logic [COLOR_W-1:0] read_color;
        logic [INDEX_W-1:0] read_index;
    } t_pixel_read;

    localparam int FRAME_CELLS = 4096;
    localparam int SLOT_CELLS  = 256;
    localparam logic [MODE_W-1:0] MODE_NONE  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    sbc_stream_if #(.T(t_cmd_item))   in_if ();
    sbc_stream_if #(.T(t_pixel_read)) out_if ();

    sprite_blitter_with_clipping u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_if      (in_if),
        .out_if     (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // mirror of the block
    logic [COLOR_W-1:0] bg_mem [FRAME_CELLS];
    logic [COLOR_W-1:0] fr_mem [FRAME_CELLS];
    logic [COLOR_W-1:0] spr_mem [2*SLOT_CELLS];
    bit                 spr_wr [2*SLOT_CELLS];
    logic [6:0] reg_fw = 7'd64, reg_fh = 7'd64;
    logic [4:0] reg_sw [2] = '{5'd16, 5'd16};
    logic [4:0] reg_sh [2] = '{5'd16, 5'd16};

    t_cmd_item   cmd_q [$];
    t_pixel_read read_q [$];
    int  errors = 0;
    bit  quiet = 1'b0;
    int  in_gap = 0, out_gap = 0;

    function automatic int clampu(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int frame_w();
        return clampu(reg_fw, 64);
    endfunction

    function automatic int frame_h();
        return clampu(reg_fh, 64);
    endfunction

    function automatic int sprite_cells(int s);
        return clampu(reg_sw[s], 16) * clampu(reg_sh[s], 16);
    endfunction

    function automatic bit sprite_loaded(int s);
        for (int k = 0; k < sprite_cells(s); k++)
            if (!spr_wr[s*SLOT_CELLS + k]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void blit_sprite(t_cmd_item it);
        int fw, fh, w, h, n, ox, oy, nx, ny, k, x, y, base;
        bit rev, trans;
        fw = frame_w();
        fh = frame_h();
        w = clampu(reg_sw[it.slot], 16);
        h = clampu(reg_sh[it.slot], 16);
        n = w * h;
        base = it.slot * SLOT_CELLS;
        case (it.direction)
            DIR_DOWN: begin
                ox = it.bx + it.cx - it.ax; oy = it.by + it.cy - it.ay;
                rev = 0; trans = 0;
            end
            DIR_UP: begin
                ox = it.ax; oy = it.ay; rev = 1; trans = 0;
            end
            DIR_LEFT: begin
                ox = it.bx; oy = it.by; rev = 1; trans = 1;
            end
            default: begin
                ox = it.cx; oy = it.cy; rev = 0; trans = 1;
            end
        endcase
        nx = trans ? h : w;
        ny = trans ? w : h;
        for (int lx = 0; lx < nx; lx++)
            for (int ly = 0; ly < ny; ly++) begin
                k = trans ? (ly + lx*w) : (lx + ly*w);
                if (rev) k = n - 1 - k;
                x = ox + lx;
                y = fh - oy - ly;
                if (x >= 0 && y >= 0 && x < fw && y < fh)
                    fr_mem[y*fw + x] = spr_mem[base + k];
            end
    endfunction

    function automatic void fill_background(t_cmd_item it);
        int fw, fh, x0, x1, y0, y1;
        fw = frame_w();
        fh = frame_h();
        if (it.bx <= it.ax || it.by <= it.ay) return;
        x0 = it.ax; x1 = it.bx - 1;
        y0 = fh - it.by + 1; y1 = fh - it.ay;
        if (x0 < 0) x0 = 0;
        if (x1 > fw - 1) x1 = fw - 1;
        if (y0 < 0) y0 = 0;
        if (y1 > fh - 1) y1 = fh - 1;
        for (int y = y0; y <= y1; y++)
            for (int x = x0; x <= x1; x++)
                bg_mem[y*fw + x] = it.color;
    endfunction

    // update the mirror and queue the transaction
    task automatic issue(t_cmd_item it);
        t_pixel_read r;
        case (it.mode)
            MODE_LOAD: if (it.pixel_index < SLOT_CELLS) begin
                spr_mem[it.slot*SLOT_CELLS + it.pixel_index] = it.color;
                spr_wr[it.slot*SLOT_CELLS + it.pixel_index] = 1'b1;
            end
            MODE_FILL: fill_background(it);
            MODE_COPY: for (int i = 0; i < frame_w()*frame_h(); i++) fr_mem[i] = bg_mem[i];
            MODE_DRAW: blit_sprite(it);
            MODE_READ: begin
                r.read_color = fr_mem[it.pixel_index];
                r.read_index = it.pixel_index;
                read_q = {read_q, r};
            end
            default: ;
        endcase
        cmd_q = {cmd_q, it};
    endtask

    task automatic drain(int tail);
        while (cmd_q.size() != 0 || in_if.valid || read_q.size() != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[CFG_DAT_W-1:0];
        case (idx)
            REG_FRAME_W: reg_fw = val[6:0];
            REG_FRAME_H: reg_fh = val[6:0];
            REG_SLOT0_W: reg_sw[0] = val[4:0];
            REG_SLOT0_H: reg_sh[0] = val[4:0];
            REG_SLOT1_W: reg_sw[1] = val[4:0];
            default:     reg_sh[1] = val[4:0];
        endcase
    endtask

    task automatic set_sizes(int fw, int fh, int w0, int h0, int w1, int h1);
        drain(4200);
        write_reg(REG_FRAME_W, fw);
        write_reg(REG_FRAME_H, fh);
        write_reg(REG_SLOT0_W, w0);
        write_reg(REG_SLOT0_H, h0);
        write_reg(REG_SLOT1_W, w1);
        write_reg(REG_SLOT1_H, h1);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [COORD_W-1:0] pick_coord(int lim);
        if ($urandom_range(0, 15) == 0) return COORD_W'($urandom);
        return COORD_W'($urandom_range(0, lim + 16) - 8);
    endfunction

    function automatic t_cmd_item rand_item(logic [MODE_W-1:0] m);
        t_cmd_item it;
        int lim;
        lim = (frame_w() > frame_h()) ? frame_w() : frame_h();
        it.mode = m;
        it.slot = 1'($urandom_range(0, 1));
        it.direction = DIR_W'($urandom_range(0, 3));
        it.ax = pick_coord(lim);
        it.ay = pick_coord(lim);
        it.bx = pick_coord(lim);
        it.by = pick_coord(lim);
        it.cx = pick_coord(lim);
        it.cy = pick_coord(lim);
        it.color = COLOR_W'($urandom);
        it.pixel_index = INDEX_W'($urandom);
        if (m == MODE_LOAD && $urandom_range(0, 7) != 0)
            it.pixel_index = INDEX_W'($urandom_range(0, SLOT_CELLS - 1));
        if (m == MODE_FILL && $urandom_range(0, 3) != 0) begin
            it.bx = it.ax + COORD_W'($urandom_range(0, 12));
            it.by = it.ay + COORD_W'($urandom_range(0, 12));
        end
        return it;
    endfunction

    // next unloaded pixel of a slot, so that draws become legal
    function automatic t_cmd_item next_load(int s);
        t_cmd_item it;
        it = rand_item(MODE_LOAD);
        it.slot = 1'(s);
        for (int k = 0; k < SLOT_CELLS; k++)
            if (!spr_wr[s*SLOT_CELLS + k]) begin
                it.pixel_index = INDEX_W'(k);
                break;
            end
        return it;
    endfunction

    // command driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_if.data  <= '0;
        end else if (!in_if.valid || in_if.ready) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                in_if.valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                in_gap <= $urandom_range(1, 14) - 1;
                in_if.valid <= 1'b0;
            end else if (cmd_q.size() != 0) begin
                in_if.valid <= 1'b1;
                in_if.data  <= cmd_q.pop_front();
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // result monitor, with random back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (read_q.size() == 0) begin
                    $display("%0t: unexpected read result %h idx %0d", $time,
                             out_if.data.read_color, out_if.data.read_index);
                    errors <= errors + 1;
                end else if (out_if.data !== read_q[0]) begin
                    $display("%0t: read mismatch exp color %h idx %0d got color %h idx %0d",
                             $time, read_q[0].read_color, read_q[0].read_index,
                             out_if.data.read_color, out_if.data.read_index);
                    errors <= errors + 1;
                    void'(read_q.pop_front());
                end else begin
                    void'(read_q.pop_front());
                end
            end
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                out_if.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                out_gap <= $urandom_range(1, 14) - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        t_cmd_item it;
        int pick, phase;
        for (int i = 0; i < FRAME_CELLS; i++) begin
            bg_mem[i] = '0;
            fr_mem[i] = '0;
        end
        for (int i = 0; i < 2*SLOT_CELLS; i++) begin
            spr_mem[i] = '0;
            spr_wr[i] = 1'b0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: full copy makes every frame entry readable
        issue(rand_item(MODE_COPY));
        it = rand_item(MODE_FILL);
        it.ax = -12'sd2048; it.ay = -12'sd2048; it.bx = 12'sd2047; it.by = 12'sd2047;
        it.color = 24'hFFFFFF;
        issue(it);
        it.ax = 12'sd10; it.bx = 12'sd10; it.color = 24'h000000;   // empty extent
        issue(it);
        it = rand_item(MODE_FILL);
        it.ax = 12'sd5; it.ay = 12'sd3; it.bx = 12'sd9; it.by = 12'sd8; it.color = 24'h123456;
        issue(it);
        issue(rand_item(MODE_COPY));
        it = rand_item(MODE_READ); it.pixel_index = 12'd0; issue(it);
        it.pixel_index = 12'd4095; issue(it);
        issue(rand_item(MODE_NONE));
        issue(rand_item(MODE_SPARE));
        it = rand_item(MODE_LOAD); it.pixel_index = 12'd4095; issue(it);  // ignored
        set_sizes(0, 127, 2, 0, 31, 1);
        for (int k = 0; k < 2; k++) begin
            it = rand_item(MODE_LOAD); it.slot = 1'b0; it.pixel_index = INDEX_W'(k); issue(it);
        end
        for (int d = 0; d < 4; d++) begin
            it = rand_item(MODE_DRAW);
            it.slot = 1'b0; it.direction = DIR_W'(d);
            it.ax = 12'sd0; it.ay = 12'sd0; it.bx = 12'sd1; it.by = 12'sd1;
            it.cx = 12'sd0; it.cy = 12'sd2;
            issue(it);
        end
        it = rand_item(MODE_READ); it.pixel_index = 12'd0; issue(it);
        it.pixel_index = 12'd1; issue(it);

        // random phases
        for (phase = 0; phase < 9; phase++) begin
            case (phase)
                0: set_sizes(64, 64, 16, 16, 16, 16);
                1: set_sizes(1, 1, 1, 1, 16, 16);
                8: set_sizes(64, 64, 16, 16, 16, 16);
                default: set_sizes($urandom_range(0, 40), $urandom_range(0, 40),
                                   $urandom_range(0, 20), $urandom_range(0, 20),
                                   $urandom_range(0, 20), $urandom_range(0, 20));
            endcase
            if (phase == 8) quiet = 1'b1;
            for (int n = 0; n < 125; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 22) it = rand_item(MODE_LOAD);
                else if (pick < 38) it = rand_item(MODE_FILL);
                else if (pick < 41 && (frame_w()*frame_h() <= 1600 || pick == 40))
                    it = rand_item(MODE_COPY);
                else if (pick < 66) it = rand_item(MODE_DRAW);
                else if (pick < 97) it = rand_item(MODE_READ);
                else it = rand_item(MODE_W'($urandom_range(MODE_NONE, MODE_SPARE)));
                if (it.mode == MODE_DRAW && !sprite_loaded(it.slot))
                    it = next_load(it.slot);
                issue(it);
            end
        end

        drain(4200);
        if (errors == 0)
            $display("[sprite_blitter_with_clipping] OK");
        else
            $display("[sprite_blitter_with_clipping] ERROR");
        $finish;
    end

    initial begin
        #400_000_000;
        $display("[sprite_blitter_with_clipping] ERROR");
        $finish;
    end
endmodule
